FILE: src/dbse_pkg.sv
// shared constants and entry types for the decayed bucket success estimator
`default_nettype none
package dbse_pkg;

	localparam int BUCKETS      = 64;
	localparam int MAX_CONFIRMS = 32;
	localparam int BIDX_W       = $clog2(BUCKETS);
	localparam int CONF_ENTRIES = BUCKETS * MAX_CONFIRMS;
	localparam int CADDR_W      = $clog2(CONF_ENTRIES);
	localparam int DEL_W        = $clog2(MAX_CONFIRMS + 1);
	localparam int ACC_W        = 48 + BIDX_W;
	localparam int PROD_W       = ACC_W + 17;
	localparam int REM_W        = ACC_W + 1;

	// request codes
	localparam logic [1:0] REQ_LOAD   = 2'd0;
	localparam logic [1:0] REQ_RECORD = 2'd1;
	localparam logic [1:0] REQ_BLOCK  = 2'd2;
	localparam logic [1:0] REQ_QUERY  = 2'd3;

	// result status codes
	localparam logic [1:0] ST_FOUND = 2'd0;
	localparam logic [1:0] ST_NONE  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	// register indexes
	localparam logic [2:0] CFG_DECAY  = 3'd0;
	localparam logic [2:0] CFG_SUFF   = 3'd1;
	localparam logic [2:0] CFG_MINSUC = 3'd2;
	localparam logic [2:0] CFG_BCOUNT = 3'd3;
	localparam logic [2:0] CFG_CDEPTH = 3'd4;

	// register reset values
	localparam logic [15:0] RST_DECAY  = 16'd65405;
	localparam logic [47:0] RST_SUFF   = 48'd32768000;
	localparam logic [16:0] RST_MINSUC = 17'd55706;
	localparam logic [6:0]  RST_BCOUNT = 7'd64;
	localparam logic [5:0]  RST_CDEPTH = 6'd25;

	// one confirmation counter entry
	typedef struct packed {
		logic [15:0] pend;
		logic [47:0] dec;
	} conf_t;

	// one bucket entry
	typedef struct packed {
		logic [15:0] ptx;
		logic [47:0] psum;
		logic [47:0] dtx;
		logic [63:0] dsum;
	} bkt_t;

endpackage
`default_nettype wire

FILE: src/dbse_ram.sv
// generic simple dual port ram with registered read
`default_nettype none
module dbse_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: src/dbse_div.sv
// radix-2 divider: floor(dividend * 2^16 / divisor), saturated to 48 bits
`default_nettype none
module dbse_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] dividend,
	input  wire logic [47:0] divisor,
	output      logic        done,
	output      logic [47:0] quotient
);
	localparam int NUM_W = 80;
	localparam int CNT_W = $clog2(NUM_W);
	localparam int Q_W   = 48;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [Q_W-1:0]   den_q;
	logic [Q_W-1:0]   rem_q;
	logic [Q_W-1:0]   quo_q;
	logic             ovf_q;
	logic [Q_W:0]     trial;
	logic             qbit;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign qbit  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {dividend, 16'h0000};
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			rem_q <= qbit ? Q_W'(trial - {1'b0, den_q}) : trial[Q_W-1:0];
			quo_q <= {quo_q[Q_W-2:0], qbit};
			// quotient bits above bit 47 mean saturation
			ovf_q <= ovf_q | (qbit && (cnt_q >= CNT_W'(Q_W)));
		end
	end

	assign done     = done_q;
	assign quotient = ovf_q ? {Q_W{1'b1}} : quo_q;
endmodule
`default_nettype wire

FILE: src/decayed_bucket_success_estimator.sv
// top level: decayed bucket success estimator with memory based state
//
// channel | handshake            | payload
// --------+----------------------+------------------------------------------------
// in      | in_valid / in_ready  | req_type bucket_index bound_value sample_value
//         |                      | blocks_to_confirm block_height conf_target
// out     | out_valid/out_ready  | status estimate low_bucket high_bucket
// cfg     | cfg_valid/cfg_ready  | cfg_index cfg_data (write only, always ready)
//
// after reset a clearing pass zeroes both state memories, in_ready low
// load: writes the bound; record: scans bounds, bumps each tracked delay, then the bucket
// block end: a sweep over every counter entry, then every bucket, with one shared
//   48x17 multiplier feeding the read-modify-write sweep
// query: walks buckets downward, sums and searches the chosen range, then divides
// one beat is worked at a time; a finished result waits in the output register
`default_nettype none
module decayed_bucket_success_estimator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_ready,
	input  wire logic [1:0]  req_type,
	input  wire logic [5:0]  bucket_index,
	input  wire logic [31:0] bound_value,
	input  wire logic [31:0] sample_value,
	input  wire logic [15:0] blocks_to_confirm,
	input  wire logic [31:0] block_height,
	input  wire logic [15:0] conf_target,
	output      logic        out_valid,
	input  wire logic        out_ready,
	output      logic [1:0]  status,
	output      logic [47:0] estimate,
	output      logic [5:0]  low_bucket,
	output      logic [5:0]  high_bucket,
	input  wire logic        cfg_valid,
	output      logic        cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [47:0] cfg_data
);
	import dbse_pkg::*;

	// sequencer codes
	localparam logic [4:0] S_CLEAR  = 5'd0;
	localparam logic [4:0] S_IDLE   = 5'd1;
	localparam logic [4:0] S_SC_RD  = 5'd2;
	localparam logic [4:0] S_SC_CHK = 5'd3;
	localparam logic [4:0] S_RC_RD  = 5'd4;
	localparam logic [4:0] S_RC_WR  = 5'd5;
	localparam logic [4:0] S_BK_RD  = 5'd6;
	localparam logic [4:0] S_BK_WR  = 5'd7;
	localparam logic [4:0] S_FC_RD  = 5'd8;
	localparam logic [4:0] S_FC_MUL = 5'd9;
	localparam logic [4:0] S_FC_WR  = 5'd10;
	localparam logic [4:0] S_FB_RD  = 5'd11;
	localparam logic [4:0] S_FB_M1  = 5'd12;
	localparam logic [4:0] S_FB_M2  = 5'd13;
	localparam logic [4:0] S_FB_M3  = 5'd14;
	localparam logic [4:0] S_FB_WR  = 5'd15;
	localparam logic [4:0] S_Q_RD   = 5'd16;
	localparam logic [4:0] S_Q_ACC  = 5'd17;
	localparam logic [4:0] S_Q_CMP  = 5'd18;
	localparam logic [4:0] S_Q_RAT  = 5'd19;
	localparam logic [4:0] S_S_RD   = 5'd20;
	localparam logic [4:0] S_S_ACC  = 5'd21;
	localparam logic [4:0] S_M_RD   = 5'd22;
	localparam logic [4:0] S_M_CHK  = 5'd23;
	localparam logic [4:0] S_DIV    = 5'd24;
	localparam logic [4:0] S_OUT    = 5'd25;

	// multiplier of one, used when a sweep only clears pending counts
	localparam logic [16:0] ONE_Q16 = 17'h10000;
	localparam logic [BIDX_W-1:0] LAST_B = BIDX_W'(BUCKETS - 1);
	localparam logic [CADDR_W-1:0] LAST_K = CADDR_W'(CONF_ENTRIES - 1);

	// configuration registers
	logic [15:0] decay_q;
	logic [47:0] suff_q;
	logic [16:0] minsuc_q;
	logic [6:0]  bcount_q;
	logic [5:0]  cdepth_q;

	// control
	logic [4:0]         state_q;
	logic [CADDR_W-1:0] k_q;
	logic [BIDX_W-1:0]  j_q;
	logic [DEL_W-1:0]   i_q;
	logic [BIDX_W-1:0]  b_q;
	logic [DEL_W-1:0]   tgt_q;
	logic               fold_q;
	logic               found_q;
	logic [31:0]        best_height_q;
	logic               out_valid_q;

	// payload
	logic [31:0]       val_q;
	logic [15:0]       blk_q;
	logic [15:0]       cpend_q;
	bkt_t              bq_q;
	logic [64:0]       mp_q;
	logic [47:0]       tx_new_q;
	logic [63:0]       acc64_q;
	logic [ACC_W-1:0]  conf_acc_q;
	logic [ACC_W-1:0]  tot_acc_q;
	logic [PROD_W-1:0] prod_q;
	logic [ACC_W-1:0]  sum_q;
	logic [REM_W-1:0]  rem_q;
	logic [BIDX_W-1:0] cur_high_q;
	logic [BIDX_W-1:0] best_high_q;
	logic [BIDX_W-1:0] best_low_q;
	logic [1:0]        res_status_q;
	logic [47:0]       res_est_q;
	logic [BIDX_W-1:0] res_low_q;
	logic [BIDX_W-1:0] res_high_q;
	logic [1:0]        status_q;
	logic [47:0]       estimate_q;
	logic [5:0]        low_q;
	logic [5:0]        high_q;

	// clamped register views
	logic [6:0]        nb;
	logic [BIDX_W-1:0] maxb;
	logic [DEL_W-1:0]  nd;

	always_comb begin
		if (bcount_q < 7'd2) begin
			nb = 7'd2;
		end else if (bcount_q > 7'(BUCKETS)) begin
			nb = 7'(BUCKETS);
		end else begin
			nb = bcount_q;
		end
		if (cdepth_q < 6'd1) begin
			nd = DEL_W'(1);
		end else if (cdepth_q > 6'(MAX_CONFIRMS)) begin
			nd = DEL_W'(MAX_CONFIRMS);
		end else begin
			nd = DEL_W'(cdepth_q);
		end
	end
	assign maxb = BIDX_W'(nb - 7'd1);

	// memories
	logic               conf_we;
	logic [CADDR_W-1:0] conf_waddr;
	conf_t              conf_wdata;
	logic [CADDR_W-1:0] conf_raddr;
	conf_t              conf_rd;
	logic               bkt_we;
	logic [BIDX_W-1:0]  bkt_waddr;
	bkt_t               bkt_wdata;
	logic [BIDX_W-1:0]  bkt_raddr;
	bkt_t               bkt_rd;
	logic               bnd_we;
	logic [31:0]        bnd_rd;

	logic [CADDR_W-1:0] rc_addr;
	logic [CADDR_W-1:0] q_addr;

	assign rc_addr = CADDR_W'(CADDR_W'(i_q - DEL_W'(1)) * CADDR_W'(BUCKETS)) + CADDR_W'(b_q);
	assign q_addr  = CADDR_W'(CADDR_W'(tgt_q - DEL_W'(1)) * CADDR_W'(BUCKETS)) + CADDR_W'(j_q);

	dbse_ram #(.WIDTH($bits(conf_t)), .DEPTH(CONF_ENTRIES)) u_conf_ram (
		.clk   (clk),
		.we    (conf_we),
		.waddr (conf_waddr),
		.wdata (conf_wdata),
		.raddr (conf_raddr),
		.rdata (conf_rd)
	);

	dbse_ram #(.WIDTH($bits(bkt_t)), .DEPTH(BUCKETS)) u_bkt_ram (
		.clk   (clk),
		.we    (bkt_we),
		.waddr (bkt_waddr),
		.wdata (bkt_wdata),
		.raddr (bkt_raddr),
		.rdata (bkt_rd)
	);

	dbse_ram #(.WIDTH(32), .DEPTH(BUCKETS)) u_bnd_ram (
		.clk   (clk),
		.we    (bnd_we),
		.waddr (bucket_index),
		.wdata (bound_value),
		.raddr (j_q),
		.rdata (bnd_rd)
	);

	// divider for the median bucket mean
	logic        div_start;
	logic        div_done;
	logic [47:0] div_q;

	dbse_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (bkt_rd.dsum),
		.divisor  (bkt_rd.dtx),
		.done     (div_done),
		.quotient (div_q)
	);

	// old * d >> 16 plus pending << 16, saturated at 48 bits
	function automatic logic [47:0] fold48(input logic [47:0] v, input logic [15:0] p);
		logic [48:0] s;
		s = {1'b0, v} + {17'h0, p, 16'h0000};
		return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
	endfunction

	logic        in_acc;
	logic [16:0] dm;
	logic [47:0] mul_a;
	logic [15:0] pend_gate;
	logic [15:0] ptx_gate;
	logic [47:0] psum_gate;
	logic [65:0] sum64;
	logic [63:0] sum64_sat;
	logic [48:0] psum_add;
	logic [ACC_W-1:0] sum_next;
	logic [REM_W-1:0] c2;
	logic        c_less;

	assign in_acc    = in_valid && in_ready;
	assign in_ready  = state_q == S_IDLE;
	assign cfg_ready = 1'b1;
	assign bnd_we    = in_acc && (req_type == REQ_LOAD);

	// with no fold the multiplier passes the old value through unchanged
	assign dm        = fold_q ? {1'b0, decay_q} : ONE_Q16;
	assign pend_gate = fold_q ? cpend_q : 16'h0000;
	assign ptx_gate  = fold_q ? bq_q.ptx : 16'h0000;
	assign psum_gate = fold_q ? bq_q.psum : 48'h0;

	always_comb begin
		unique case (state_q)
			S_FC_MUL: mul_a = conf_rd.dec;
			S_FB_M1:  mul_a = bkt_rd.dtx;
			S_FB_M2:  mul_a = bq_q.dsum[63:16];
			S_FB_M3:  mul_a = {32'h0, bq_q.dsum[15:0]};
			default:  mul_a = 48'h0;
		endcase
	end

	assign sum64     = {2'b00, acc64_q} + {17'h0, mp_q[64:16]} + {2'b00, psum_gate, 16'h0000};
	assign sum64_sat = (sum64[65:64] != 2'b00) ? {64{1'b1}} : sum64[63:0];
	assign psum_add  = {1'b0, bkt_rd.psum} + {17'h0, val_q};
	assign sum_next  = sum_q + ACC_W'(bkt_rd.dtx);
	assign c2        = REM_W'({bkt_rd.dtx, 1'b0});
	assign c_less    = c2 < rem_q;
	assign div_start = (state_q == S_M_CHK) && !c_less && (bkt_rd.dtx != 48'h0);

	// memory ports
	always_comb begin
		conf_we    = 1'b0;
		conf_waddr = k_q;
		conf_wdata = '0;
		bkt_we     = 1'b0;
		bkt_waddr  = j_q;
		bkt_wdata  = '0;
		unique case (state_q)
			S_CLEAR: begin
				conf_we   = 1'b1;
				bkt_we    = k_q < CADDR_W'(BUCKETS);
				bkt_waddr = k_q[BIDX_W-1:0];
			end
			S_RC_WR: begin
				conf_we         = 1'b1;
				conf_waddr      = rc_addr;
				conf_wdata.dec  = conf_rd.dec;
				conf_wdata.pend = (conf_rd.pend == 16'hFFFF) ? conf_rd.pend
					: conf_rd.pend + 16'd1;
			end
			S_FC_WR: begin
				conf_we        = 1'b1;
				conf_wdata.dec = fold48(mp_q[63:16], pend_gate);
			end
			S_BK_WR: begin
				bkt_we         = 1'b1;
				bkt_waddr      = b_q;
				bkt_wdata      = bkt_rd;
				bkt_wdata.ptx  = (bkt_rd.ptx == 16'hFFFF) ? bkt_rd.ptx : bkt_rd.ptx + 16'd1;
				bkt_wdata.psum = psum_add[48] ? 48'hFFFF_FFFF_FFFF : psum_add[47:0];
			end
			S_FB_WR: begin
				bkt_we         = 1'b1;
				bkt_wdata.dtx  = tx_new_q;
				bkt_wdata.dsum = sum64_sat;
			end
			default: begin
			end
		endcase
	end

	assign conf_raddr = (state_q == S_FC_RD) ? k_q : ((state_q == S_Q_RD) ? q_addr : rc_addr);
	assign bkt_raddr  = (state_q == S_BK_RD) ? b_q : j_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_q  <= RST_DECAY;
			suff_q   <= RST_SUFF;
			minsuc_q <= RST_MINSUC;
			bcount_q <= RST_BCOUNT;
			cdepth_q <= RST_CDEPTH;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_DECAY:  decay_q  <= cfg_data[15:0];
				CFG_SUFF:   suff_q   <= cfg_data;
				CFG_MINSUC: minsuc_q <= cfg_data[16:0];
				CFG_BCOUNT: bcount_q <= cfg_data[6:0];
				CFG_CDEPTH: cdepth_q <= cfg_data[5:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			k_q           <= '0;
			j_q           <= '0;
			i_q           <= '0;
			b_q           <= '0;
			tgt_q         <= '0;
			fold_q        <= 1'b0;
			found_q       <= 1'b0;
			best_height_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					k_q <= k_q + 1'b1;
					if (k_q == LAST_K) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						unique case (req_type)
							REQ_LOAD: begin
							end
							REQ_RECORD: begin
								// a zero delay is dropped
								if (blocks_to_confirm != 16'h0) begin
									j_q     <= '0;
									state_q <= S_SC_RD;
								end
							end
							REQ_BLOCK: begin
								fold_q <= block_height > best_height_q;
								if (block_height > best_height_q) begin
									best_height_q <= block_height;
								end
								k_q     <= '0;
								state_q <= S_FC_RD;
							end
							REQ_QUERY: begin
								found_q <= 1'b0;
								j_q     <= maxb;
								tgt_q   <= DEL_W'(conf_target);
								if ((conf_target == 16'h0) || (conf_target > 16'(nd))) begin
									state_q <= S_OUT;
								end else begin
									state_q <= S_Q_RD;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_SC_RD: state_q <= S_SC_CHK;
				S_SC_CHK: begin
					// first bound above the sample, else the top bucket in use
					if ((bnd_rd > val_q) || (j_q == maxb)) begin
						b_q <= j_q;
						if (blk_q > 16'(nd)) begin
							state_q <= S_BK_RD;
						end else begin
							i_q     <= DEL_W'(blk_q);
							state_q <= S_RC_RD;
						end
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= S_SC_RD;
					end
				end
				S_RC_RD: state_q <= S_RC_WR;
				S_RC_WR: begin
					if (i_q == nd) begin
						state_q <= S_BK_RD;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_RC_RD;
					end
				end
				S_BK_RD: state_q <= S_BK_WR;
				S_BK_WR: state_q <= S_IDLE;
				S_FC_RD: state_q <= S_FC_MUL;
				S_FC_MUL: state_q <= S_FC_WR;
				S_FC_WR: begin
					k_q <= k_q + 1'b1;
					if (k_q == LAST_K) begin
						j_q     <= '0;
						state_q <= S_FB_RD;
					end else begin
						state_q <= S_FC_RD;
					end
				end
				S_FB_RD: state_q <= S_FB_M1;
				S_FB_M1: state_q <= S_FB_M2;
				S_FB_M2: state_q <= S_FB_M3;
				S_FB_M3: state_q <= S_FB_WR;
				S_FB_WR: begin
					if (j_q == LAST_B) begin
						state_q <= S_IDLE;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= S_FB_RD;
					end
				end
				S_Q_RD: state_q <= S_Q_ACC;
				S_Q_ACC: state_q <= S_Q_CMP;
				S_Q_CMP: begin
					if (tot_acc_q >= ACC_W'(suff_q)) begin
						state_q <= S_Q_RAT;
					end else if (j_q == '0) begin
						j_q     <= best_low_q;
						state_q <= S_S_RD;
					end else begin
						j_q     <= j_q - 1'b1;
						state_q <= S_Q_RD;
					end
				end
				S_Q_RAT: begin
					if ({1'b0, conf_acc_q, 16'h0000} < prod_q) begin
						// ratio failed: stop the walk
						j_q     <= best_low_q;
						state_q <= S_S_RD;
					end else begin
						found_q <= 1'b1;
						if (j_q == '0) begin
							j_q     <= '0;
							state_q <= S_S_RD;
						end else begin
							j_q     <= j_q - 1'b1;
							state_q <= S_Q_RD;
						end
					end
				end
				S_S_RD: state_q <= S_S_ACC;
				S_S_ACC: begin
					if (j_q == best_high_q) begin
						if (found_q && (sum_next != '0)) begin
							j_q     <= best_low_q;
							state_q <= S_M_RD;
						end else begin
							state_q <= S_OUT;
						end
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= S_S_RD;
					end
				end
				S_M_RD: state_q <= S_M_CHK;
				S_M_CHK: begin
					if (c_less) begin
						j_q     <= j_q + 1'b1;
						state_q <= S_M_RD;
					end else if (div_start) begin
						state_q <= S_DIV;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		mp_q <= 65'(mul_a * dm);
		unique case (state_q)
			S_IDLE: begin
				val_q        <= sample_value;
				blk_q        <= blocks_to_confirm;
				conf_acc_q   <= '0;
				tot_acc_q    <= '0;
				cur_high_q   <= maxb;
				best_high_q  <= maxb;
				best_low_q   <= maxb;
				// out of range target result
				res_status_q <= ST_RANGE;
				res_est_q    <= '0;
				res_low_q    <= '0;
				res_high_q   <= '0;
			end
			S_FC_MUL: cpend_q <= conf_rd.pend;
			S_FB_M1:  bq_q <= bkt_rd;
			S_FB_M2:  tx_new_q <= fold48(mp_q[63:16], ptx_gate);
			S_FB_M3:  acc64_q <= mp_q[63:0];
			S_Q_ACC: begin
				conf_acc_q <= conf_acc_q + ACC_W'(conf_rd.dec);
				tot_acc_q  <= tot_acc_q + ACC_W'(bkt_rd.dtx);
			end
			S_Q_CMP: prod_q <= PROD_W'(tot_acc_q * minsuc_q);
			S_Q_RAT: begin
				sum_q <= '0;
				if ({1'b0, conf_acc_q, 16'h0000} >= prod_q) begin
					conf_acc_q  <= '0;
					tot_acc_q   <= '0;
					best_high_q <= cur_high_q;
					best_low_q  <= j_q;
					cur_high_q  <= j_q - 1'b1;
				end
			end
			S_S_ACC: begin
				sum_q        <= sum_next;
				rem_q        <= {sum_next, 1'b0};
				res_status_q <= ST_NONE;
				res_low_q    <= best_low_q;
				res_high_q   <= best_high_q;
			end
			S_M_CHK: begin
				if (c_less) begin
					rem_q <= rem_q - c2;
				end
			end
			S_DIV: begin
				if (div_done) begin
					res_status_q <= ST_FOUND;
					res_est_q    <= div_q;
				end
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					status_q   <= res_status_q;
					estimate_q <= res_est_q;
					low_q      <= 6'(res_low_q);
					high_q     <= 6'(res_high_q);
				end
			end
			default: begin
			end
		endcase
		// a walk that ends without a ratio test clears the bucket sum too
		if (state_q == S_Q_CMP) begin
			sum_q <= '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign estimate    = estimate_q;
	assign low_bucket  = low_q;
	assign high_bucket = high_q;

	// a new result only comes out of the output state
	a_out_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_OUT)
		else $error("result raised outside output state");

	// an accepted beat never coincides with a write to either state memory
	a_no_write_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> !conf_we && !bkt_we)
		else $error("memory write while accepting a beat");

	// divider finishes only while the sequencer waits on it
	a_div_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider done outside divide state");

	// the clearing pass ends with the sweep counter wrapped
	a_clear_end: assert property (@(posedge clk) disable iff (!arst_n)
		($past(state_q) == S_CLEAR && state_q == S_IDLE) |-> k_q == '0)
		else $error("clearing pass ended early");
endmodule
`default_nettype wire
